>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/btt_pkg.sv
package btt_pkg;

    // Widths that the item fields fix.
    localparam int TAG_W   = 16;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 8;
    localparam int BEATS_W = 9;
    localparam int SLOT_W  = 8;   // enough for a table of up to 256 slots
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;
    localparam int VAC_OUT_W = 5;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEAT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OK_LAST   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NO_ID     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_PREMATURE = 3'd6;

    // Table update operations.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_BEAT   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // Lookup token that walks the row of cells, gathering what it finds.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [BEATS_W-1:0] hit_beats;
        logic [BEATS_W-1:0] hit_progress;
        logic               vac;
        logic [SLOT_W-1:0]  vac_slot;
    } token_t;

    // Update broadcast to every cell once the outcome of an item is known.
    typedef struct packed {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic [ADDR_W-1:0]  addr;
        logic [BEATS_W-1:0] beats;
        logic               wr_dir;
    } commit_t;

endpackage

>>> hdl/btt_cell.sv
module btt_cell #(
    parameter int SLOT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  btt_pkg::token_t   tok_in,
    output btt_pkg::token_t   tok_out,
    input  btt_pkg::commit_t  commit
);
    import btt_pkg::*;

    logic               valid_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [ADDR_W-1:0]  addr_reg;      // start address of the tracked burst
    logic [BEATS_W-1:0] beats_reg;
    logic [BEATS_W-1:0] progress_reg;
    logic               wr_dir_reg;    // direction the burst was opened with
    token_t             tok_reg;
    token_t             tok_next;
    logic               mine;

    assign mine = (commit.slot == SLOT_W'(SLOT));

    // Add this entry's contribution to the passing token.
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid) begin
            if (!tok_in.hit && valid_reg && (tag_reg == tok_in.tag)) begin
                tok_next.hit          = 1'b1;
                tok_next.hit_slot     = SLOT_W'(SLOT);
                tok_next.hit_beats    = beats_reg;
                tok_next.hit_progress = progress_reg;
            end
            if (!tok_in.vac && !valid_reg) begin
                tok_next.vac      = 1'b1;
                tok_next.vac_slot = SLOT_W'(SLOT);
            end
        end
    end

    // Token stage towards the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // Entry occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (mine && commit.op == OP_CREATE) begin
            valid_reg <= 1'b1;
        end else if (mine && commit.op == OP_REMOVE) begin
            valid_reg <= 1'b0;
        end
    end

    // Entry contents.
    always_ff @(posedge aclk) begin
        if (mine && commit.op == OP_CREATE) begin
            tag_reg      <= commit.tag;
            addr_reg     <= commit.addr;
            beats_reg    <= commit.beats;
            progress_reg <= '0;
            wr_dir_reg   <= commit.wr_dir;
        end else if (mine && commit.op == OP_BEAT) begin
            progress_reg <= progress_reg + BEATS_W'(1);
        end
    end

endmodule

>>> hdl/btt_ctrl.sv
module btt_ctrl #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [87:0]              s_tdata,
    input  logic [btt_pkg::KIND_W-1:0] s_tuser,
    input  logic                     s_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,
    output logic [btt_pkg::STAT_W-1:0] m_tuser,
    output btt_pkg::token_t          launch,
    input  btt_pkg::token_t          tok_end,
    output btt_pkg::commit_t         commit
);
    import btt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                last_reg;
    logic                dir_reg;
    token_t              launch_reg, launch_next;
    token_t              fin_reg;
    logic [CNT_W-1:0]    vac_cnt_reg, vac_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [VAC_OUT_W-1:0] vac_out_reg, vac_out_next;
    logic                s_accept;
    logic                out_free;
    logic                finish;
    logic [BEATS_W-1:0]  new_beats;
    logic [8:0]          cnt_wide;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == S_DONE) && out_free;
    assign cfg_ready = 1'b1;
    assign new_beats = {1'b0, len_reg} + BEATS_W'(1);

    // Sequencer: accept, walk the row, then commit and report.
    always_comb begin
        state_next  = state_reg;
        launch_next = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    launch_next.valid = 1'b1;
                    launch_next.tag   = s_tdata[TAG_W-1:0];
                    state_next        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_end.valid) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outcome of the finished lookup and the matching table update.
    always_comb begin
        commit          = '0;
        commit.slot     = fin_reg.hit_slot;
        commit.tag      = fin_reg.tag;
        commit.addr     = addr_reg;
        commit.beats    = new_beats;
        commit.wr_dir   = dir_reg;
        status_next     = STAT_OK;
        vac_cnt_next    = vac_cnt_reg;
        case (kind_reg)
            KIND_CREATE: begin
                if (fin_reg.hit) begin
                    status_next = STAT_DUPLICATE;
                end else if (!fin_reg.vac) begin
                    status_next = STAT_FULL;
                end else begin
                    commit.op    = OP_CREATE;
                    commit.slot  = fin_reg.vac_slot;
                    vac_cnt_next = vac_cnt_reg - CNT_W'(1);
                end
            end
            KIND_BEAT: begin
                if (!fin_reg.hit) begin
                    status_next = STAT_NO_ID;
                end else if (fin_reg.hit_progress >= fin_reg.hit_beats) begin
                    status_next = STAT_OVERFLOW;
                end else if (last_reg &&
                             (fin_reg.hit_progress + BEATS_W'(1)) != fin_reg.hit_beats) begin
                    status_next = STAT_PREMATURE;
                end else begin
                    commit.op   = OP_BEAT;
                    status_next = last_reg ? STAT_OK_LAST : STAT_OK;
                end
            end
            KIND_REMOVE: begin
                if (!fin_reg.hit) begin
                    status_next = STAT_NO_ID;
                end else begin
                    commit.op    = OP_REMOVE;
                    vac_cnt_next = vac_cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
        if (!finish) begin
            commit.op    = OP_NONE;
            vac_cnt_next = vac_cnt_reg;
        end
    end

    // Vacant count after the update, saturated to the result field.
    always_comb begin
        cnt_wide     = 9'(vac_cnt_next);
        vac_out_next = (cnt_wide > 9'd31) ? 5'd31 : cnt_wide[VAC_OUT_W-1:0];
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            launch_reg   <= '0;
            vac_cnt_reg  <= CNT_W'(TABLE_DEPTH);
            m_tvalid_reg <= 1'b0;
            dir_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            vac_cnt_reg  <= vac_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                dir_reg <= cfg_data;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= s_tuser;
            addr_reg <= s_tdata[TAG_W +: ADDR_W];
            len_reg  <= s_tdata[TAG_W+ADDR_W +: LEN_W];
            last_reg <= s_tlast;
        end
        if (state_reg == S_SCAN && tok_end.valid) begin
            fin_reg <= tok_end;
        end
        if (finish) begin
            status_reg  <= status_next;
            vac_out_reg <= vac_out_next;
        end
    end

    assign launch   = launch_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, vac_out_reg};

endmodule

>>> hdl/burst_transaction_tracker_top.sv
// Tracker of outstanding burst transactions, keyed by a 16-bit transaction ID, with
// TABLE_DEPTH entries held in a row of cells. Each input transaction (create, data beat
// or remove, selected by s_tuser) yields exactly one result: a status on m_tuser and the
// number of vacant entries on m_tdata. Items are handled one at a time: the next one is
// accepted only after the lookup token has stepped through the row, one cell per cycle,
// and the table has been updated. A finished result waits in the output register while
// the next transaction is accepted. The direction register (cfg_data) is copied into
// every entry that a create opens.
module burst_transaction_tracker_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // txn_id[15:0], burst_addr[79:16], burst_len_minus_one[87:80]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        s_tlast,   // beat_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,  // write_direction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // vacant_slots[4:0], zero [7:5]
    output logic [2:0]  m_tuser    // status[2:0]
);
    import btt_pkg::*;

    token_t  tok [0:TABLE_DEPTH];
    commit_t commit;

    // Sequencer, counters and result register.
    btt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .launch   (tok[0]),
        .tok_end  (tok[TABLE_DEPTH]),
        .commit   (commit)
    );

    // Row of entry cells; the token passes from each to the next.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        btt_cell #(
            .SLOT(i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .tok_in (tok[i]),
            .tok_out(tok[i+1]),
            .commit (commit)
        );
    end

endmodule

>>> hdl/btt_checker.sv
`include "assert_macros.svh"

module btt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);
    import btt_pkg::*;

    logic [10:0] m_payload;
    logic        pad_zero;

    assign m_payload = {m_tuser, m_tdata};
    assign pad_zero  = (m_tdata[7:5] == 3'd0);

    // A result held back by the sink keeps its content.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_payload))

    // Only one transaction is in the row at a time.
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A refusal for a full table reports no vacant entry.
    `ASSERT_IMPLY(a_full_empty, aclk, aresetn, m_tvalid && m_tuser == STAT_FULL, m_tdata[4:0] == 5'd0)

    // Status codes stay within the defined set and padding stays zero.
    `ASSERT_IMPLY(a_status_known, aclk, aresetn, m_tvalid, m_tuser <= STAT_PREMATURE && pad_zero)

endmodule

bind burst_transaction_tracker_top btt_checker u_btt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

>>> verif/tb_burst_transaction_tracker_top.sv
module tb_burst_transaction_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import btt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEM_CYCLES = DEPTH + 3;
    localparam int HOLD_CYCLES = 250;
    localparam int IDLE_LIMIT  = 3000;

    // The fourth kind code has no meaning; the tracker answers it without change.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [4:0]        vacant;
    } reply_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [4:0]        vacant;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // txn_id[15:0], burst_addr[79:16], burst_len_minus_one[87:80]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        s_tlast;   // beat_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;  // write_direction
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // vacant_slots[4:0], zero [7:5]
    logic [2:0]  m_tuser;   // status[2:0]

    // Shadow copy of the transaction table and the direction register.
    logic               shadow_valid [DEPTH];
    logic [TAG_W-1:0]   shadow_tag [DEPTH];
    logic [ADDR_W-1:0]  shadow_addr [DEPTH];
    logic [BEATS_W-1:0] shadow_beats [DEPTH];
    logic [BEATS_W-1:0] shadow_progress [DEPTH];
    logic               shadow_wr_dir [DEPTH];
    logic               shadow_direction;

    reply_t pending_replies [$];
    int     fail_count;
    int     txn_count;
    int     reply_count;
    int     status_seen [8];
    bit     tx_gappy;
    bit     rx_gappy;
    bit     hold_req;
    int     stall_left;

    // Directed transactions; a typed row carries its expected reply.
    directed_row_t directed_rows [19] = '{
        '{KIND_REMOVE, 16'h1234, 64'h0, 8'h00, 1'b0, 1'b1, STAT_NO_ID, 5'd16},
        '{KIND_BEAT, 16'h0000, 64'h0, 8'h00, 1'b1, 1'b1, STAT_NO_ID, 5'd16},
        '{KIND_UNUSED, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, STAT_OK, 5'd16},
        '{KIND_CREATE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0, 1'b1, STAT_OK, 5'd15},
        '{KIND_CREATE, 16'hFFFF, 64'h0, 8'h00, 1'b0, 1'b1, STAT_DUPLICATE, 5'd15},
        '{KIND_CREATE, 16'h0000, 64'h0, 8'h00, 1'b1, 1'b1, STAT_OK, 5'd14},
        '{KIND_BEAT, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0, 1'b1, STAT_OK, 5'd14},
        '{KIND_BEAT, 16'h0000, 64'h0, 8'h00, 1'b1, 1'b1, STAT_OVERFLOW, 5'd14},
        '{KIND_CREATE, 16'h0001, 64'h0123_4567_89AB_CDEF, 8'h01, 1'b0, 1'b0, STAT_OK, 5'd0},
        '{KIND_BEAT, 16'h0001, 64'h0, 8'h00, 1'b1, 1'b1, STAT_PREMATURE, 5'd13},
        '{KIND_BEAT, 16'h0001, 64'h0, 8'h00, 1'b0, 1'b0, STAT_OK, 5'd0},
        '{KIND_BEAT, 16'h0001, 64'h0, 8'h00, 1'b1, 1'b0, STAT_OK, 5'd0},
        '{KIND_BEAT, 16'h0001, 64'h0, 8'h00, 1'b1, 1'b0, STAT_OK, 5'd0},
        '{KIND_REMOVE, 16'h0000, 64'h0, 8'h00, 1'b0, 1'b1, STAT_OK, 5'd14},
        '{KIND_BEAT, 16'hFFFF, 64'h0, 8'h00, 1'b1, 1'b1, STAT_PREMATURE, 5'd14},
        '{KIND_BEAT, 16'hFFFF, 64'h0, 8'h00, 1'b0, 1'b0, STAT_OK, 5'd0},
        '{KIND_REMOVE, 16'hFFFF, 64'h0, 8'h00, 1'b0, 1'b1, STAT_OK, 5'd15},
        '{KIND_REMOVE, 16'h0001, 64'h0, 8'h00, 1'b0, 1'b1, STAT_OK, 5'd16},
        '{KIND_REMOVE, 16'h0001, 64'h0, 8'h00, 1'b0, 1'b1, STAT_NO_ID, 5'd16}
    };

    burst_transaction_tracker_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted transaction to the shadow table and works out its reply.
    function automatic reply_t track_item(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                          logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                          logic last);
        reply_t r;
        int hit;
        int free_slot;
        int vac;
        hit = -1;
        free_slot = -1;
        r.status = STAT_OK;
        for (int i = 0; i < DEPTH; i++) begin
            if (shadow_valid[i] && shadow_tag[i] == tag && hit < 0)
                hit = i;
            if (!shadow_valid[i] && free_slot < 0)
                free_slot = i;
        end
        case (kind)
            KIND_CREATE: begin
                if (hit >= 0) begin
                    r.status = STAT_DUPLICATE;
                end else if (free_slot < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    // The lowest vacant slot takes the new burst.
                    shadow_valid[free_slot]    = 1'b1;
                    shadow_tag[free_slot]      = tag;
                    shadow_addr[free_slot]     = addr;
                    shadow_beats[free_slot]    = {1'b0, len} + 9'd1;
                    shadow_progress[free_slot] = '0;
                    shadow_wr_dir[free_slot]   = shadow_direction;
                end
            end
            KIND_BEAT: begin
                if (hit < 0) begin
                    r.status = STAT_NO_ID;
                end else if (shadow_progress[hit] >= shadow_beats[hit]) begin
                    r.status = STAT_OVERFLOW;
                end else if (last && shadow_progress[hit] + 9'd1 != shadow_beats[hit]) begin
                    r.status = STAT_PREMATURE;
                end else begin
                    shadow_progress[hit] = shadow_progress[hit] + 9'd1;
                    r.status = last ? STAT_OK_LAST : STAT_OK;
                end
            end
            KIND_REMOVE: begin
                if (hit < 0)
                    r.status = STAT_NO_ID;
                else
                    shadow_valid[hit] = 1'b0;
            end
            default: ;
        endcase
        vac = 0;
        for (int i = 0; i < DEPTH; i++)
            if (!shadow_valid[i])
                vac++;
        r.vacant = (vac > 31) ? 5'd31 : vac[4:0];
        return r;
    endfunction

    // Offers one transaction, optionally after a gap, and records its expected reply.
    task automatic send_txn(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                            logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len, logic last,
                            logic typed, logic [STAT_W-1:0] status, logic [4:0] vacant);
        reply_t r;
        if (tx_gappy && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 14)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, addr, tag};
        s_tuser  <= kind;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        r = track_item(kind, tag, addr, len, last);
        if (typed) begin
            r.status = status;
            r.vacant = vacant;
        end
        pending_replies.push_back(r);
        txn_count++;
    endtask

    // Stops offering, then waits until every reply has come and the tracker is quiet.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge aclk);
        repeat (ITEM_CYCLES + 4) @(posedge aclk);
    endtask

    // Writes the direction register while the tracker is idle.
    task automatic write_direction(logic dir);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do @(posedge aclk); while (!cfg_ready);
        shadow_direction = dir;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_open_slot();
        int open_slots [$];
        for (int i = 0; i < DEPTH; i++)
            if (shadow_valid[i])
                open_slots.push_back(i);
        if (open_slots.size() == 0)
            return -1;
        return open_slots[$urandom_range(0, open_slots.size() - 1)];
    endfunction

    // Random traffic: mostly well-formed bursts, with broken sequences and noise mixed in.
    task automatic run_traffic(int count, int create_weight);
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              last;
        int                roll;
        int                slot;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            addr = {$urandom, $urandom};
            len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 7));
            last = 1'($urandom_range(0, 1));
            tag  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 23));
            slot = pick_open_slot();
            kind = KIND_CREATE;
            if (roll < create_weight) begin
                // Now and then reopen a tag that is still outstanding.
                if (slot >= 0 && $urandom_range(0, 7) == 0)
                    tag = shadow_tag[slot];
            end else if (roll < 88) begin
                if (slot >= 0) begin
                    tag = shadow_tag[slot];
                    if (shadow_progress[slot] < shadow_beats[slot]) begin
                        kind = KIND_BEAT;
                        last = (shadow_progress[slot] + 9'd1 == shadow_beats[slot]);
                        if ($urandom_range(0, 9) == 0)
                            last = !last;
                    end else begin
                        kind = ($urandom_range(0, 3) == 0) ? KIND_BEAT : KIND_REMOVE;
                    end
                end
            end else if (roll < 94) begin
                kind = KIND_REMOVE;
                if (slot >= 0 && $urandom_range(0, 1) == 0)
                    tag = shadow_tag[slot];
            end else begin
                kind = 2'($urandom_range(0, 3));
                tag  = 16'($urandom_range(0, 65535));
            end
            send_txn(kind, tag, addr, len, last, 1'b0, STAT_OK, 5'd0);
        end
    endtask

    // Receiver: random stall bursts, and one long hold-off when asked for.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (rx_gappy && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Reply checker: each reply is compared with the oldest expectation.
    always @(posedge aclk) begin
        reply_t exp_reply;
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            status_seen[m_tuser]++;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none expected: status %0d vacant %0d",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                exp_reply = pending_replies.pop_front();
                if (m_tuser !== exp_reply.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, exp_reply.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== {3'b000, exp_reply.vacant}) begin
                    $display("%0t: vacant slots mismatch: expected %0d actual %0d",
                             $time, exp_reply.vacant, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction is accepted anywhere.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        hold_req  = 1'b0;
        tx_gappy  = 1'b1;
        rx_gappy  = 1'b1;
        fail_count  = 0;
        txn_count   = 0;
        reply_count = 0;
        shadow_direction = DIR_READ;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_valid[i]    = 1'b0;
            shadow_tag[i]      = '0;
            shadow_addr[i]     = '0;
            shadow_beats[i]    = '0;
            shadow_progress[i] = '0;
            shadow_wr_dir[i]   = 1'b0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows straight after reset, with the direction at its reset value.
        foreach (directed_rows[i])
            send_txn(directed_rows[i].kind, directed_rows[i].tag, directed_rows[i].addr,
                     directed_rows[i].len, directed_rows[i].last, directed_rows[i].typed,
                     directed_rows[i].status, directed_rows[i].vacant);
        drain();

        // Write bursts, idling on both sides.
        write_direction(DIR_WRITE);
        run_traffic(120, 25);
        drain();

        // Read bursts while the receiver holds off, so the tracker backs up.
        write_direction(DIR_READ);
        tx_gappy = 1'b0;
        hold_req = 1'b1;
        run_traffic(80, 25);
        drain();

        // Create-heavy traffic fills the table and runs into refusals.
        write_direction(DIR_WRITE);
        tx_gappy = 1'b1;
        run_traffic(100, 70);
        drain();

        // Closing stretch at full rate with no idling.
        write_direction(DIR_READ);
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
        run_traffic(100, 20);
        drain();

        $display("Ran %0d transactions over both directions, %0d replies checked.",
                 txn_count, reply_count);
        $display("Replies: ok %0d, ok last %0d, duplicate %0d, full %0d, no id %0d, %s %0d, %s %0d",
                 status_seen[STAT_OK], status_seen[STAT_OK_LAST],
                 status_seen[STAT_DUPLICATE], status_seen[STAT_FULL],
                 status_seen[STAT_NO_ID], "overflow", status_seen[STAT_OVERFLOW],
                 "premature last", status_seen[STAT_PREMATURE]);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d replies outstanding", fail_count,
                     pending_replies.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/btt_pkg.sv
hdl/btt_cell.sv
hdl/btt_ctrl.sv
hdl/burst_transaction_tracker_top.sv
hdl/btt_checker.sv
verif/tb_burst_transaction_tracker_top.sv
